[hw/rtl/sac_pkg.sv]
package sac_pkg;

  // Configuration register fields are all 4 bits wide
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // Widest set index the set_index_bits register can ask for
  localparam int unsigned SIDX_W = (2 ** CFG_W) - 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_OFFSET = 2'd0,
    CFG_SET_INDEX   = 2'd1,
    CFG_WAYS_IN_USE = 2'd2
  } cfg_idx_e;

  localparam logic [CFG_W-1:0] LINE_OFFSET_RST = 4'd6;
  localparam logic [CFG_W-1:0] SET_INDEX_RST   = 4'd10;
  localparam logic [CFG_W-1:0] WAYS_IN_USE_RST = 4'd8;

  typedef struct packed {
    logic [CFG_W-1:0] line_offset_bits;
    logic [CFG_W-1:0] set_index_bits;
    logic [CFG_W-1:0] ways_in_use;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_LOOK
  } back_state_e;

endpackage

[hw/rtl/sac_ram.sv]
module sac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/sac_fifo.sv]
module sac_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

[hw/rtl/sac_front.sv]
module sac_front #(
  parameter int unsigned ADDR_BITS = 48,
  parameter int unsigned TID_BITS  = 8,
  parameter int unsigned SETS      = 1024,
  parameter int unsigned SETW      = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sac_pkg::cfg_t        cfg_i,
  input  logic                 in_valid_i,
  input  logic [ADDR_BITS-1:0] addr_i,
  input  logic [TID_BITS-1:0]  tid_i,
  output logic                 stall_o,
  output logic                 push_o,
  input  logic                 full_i,
  output logic [SETW-1:0]      set_o,
  output logic [ADDR_BITS-1:0] tag_o,
  output logic [TID_BITS-1:0]  tid_o
);

  import sac_pkg::*;

  // set = masked line bits mod SETS, via reciprocal multiply plus one correction
  localparam int unsigned LG      = $clog2(SETS);
  localparam int unsigned SHIFT   = SIDX_W + LG;
  localparam int unsigned RECIP_W = SHIFT + 1;
  localparam int unsigned PROD_W  = SIDX_W + RECIP_W;
  localparam int unsigned QD_W    = SIDX_W + LG + 1;
  localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((64'd1 << SHIFT) / 64'(SETS));
  localparam logic [LG:0]        SETS_C  = (LG + 1)'(SETS);

  logic                 adv;
  logic                 v1_q, v2_q;
  logic [ADDR_BITS-1:0] line_q;
  logic [TID_BITS-1:0]  tid1_q, tid2_q;
  logic [ADDR_BITS-1:0] tag_q, tag_d;
  logic [SIDX_W-1:0]    setv_q, setv_d;
  logic [SIDX_W-1:0]    quo_q, quo_d;
  logic [SIDX_W:0]      mask_full;
  logic [PROD_W-1:0]    prod;
  logic [QD_W-1:0]      qd;
  logic [SIDX_W-1:0]    rem0, rem1;
  logic [31:0]          rem_ext;

  assign adv     = !(v2_q && full_i);
  assign stall_o = !adv;
  assign push_o  = v2_q && !full_i;

  // stage 2 inputs
  always_comb begin
    mask_full = ({{SIDX_W{1'b0}}, 1'b1} << cfg_i.set_index_bits) - 1'b1;
    tag_d     = line_q >> cfg_i.set_index_bits;
    setv_d    = line_q[SIDX_W-1:0] & mask_full[SIDX_W-1:0];
    prod      = PROD_W'(setv_d) * PROD_W'(RECIP);
    quo_d     = prod[SHIFT +: SIDX_W];
  end

  // remainder correction; quotient estimate is low by at most one
  always_comb begin
    qd   = QD_W'(quo_q) * QD_W'(SETS_C);
    rem0 = setv_q - qd[SIDX_W-1:0];
    rem1 = rem0;
    if (32'(rem0) >= 32'(SETS)) begin
      rem1 = rem0 - SIDX_W'(SETS);
    end
    rem_ext = 32'(rem1);
  end

  assign set_o = rem_ext[SETW-1:0];
  assign tag_o = tag_q;
  assign tid_o = tid2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      line_q <= addr_i >> cfg_i.line_offset_bits;
      tid1_q <= tid_i;
      tag_q  <= tag_d;
      setv_q <= setv_d;
      quo_q  <= quo_d;
      tid2_q <= tid1_q;
    end
  end

endmodule

[hw/rtl/sac_back.sv]
module sac_back #(
  parameter int unsigned ADDR_BITS = 48,
  parameter int unsigned TID_BITS  = 8,
  parameter int unsigned SETS      = 1024,
  parameter int unsigned SETW      = 10,
  parameter int unsigned WAYS      = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sac_pkg::cfg_t        cfg_i,
  input  logic                 q_valid_i,
  input  logic [SETW-1:0]      q_set_i,
  input  logic [ADDR_BITS-1:0] q_tag_i,
  input  logic [TID_BITS-1:0]  q_tid_i,
  output logic                 q_pop_o,
  output logic                 clearing_o,
  output logic                 hit_o,
  output logic                 result_valid_o
);

  import sac_pkg::*;

  localparam int unsigned RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  // entry: {valid, rank, owner, tag}
  localparam int unsigned EW     = 1 + RANK_W + TID_BITS + ADDR_BITS;
  localparam int unsigned ROW_W  = WAYS * EW;

  back_state_e          state_q, state_d;
  logic [SETW-1:0]      clr_cnt_q;
  logic [SETW-1:0]      set_q;
  logic [ADDR_BITS-1:0] tag_q;
  logic [TID_BITS-1:0]  tid_q;
  logic                 hit_q, rv_q;

  logic                 ram_we;
  logic [SETW-1:0]      ram_waddr;
  logic [ROW_W-1:0]     ram_wdata;
  logic [ROW_W-1:0]     ram_rdata;
  logic [ROW_W-1:0]     new_row;

  logic                 vld   [WAYS];
  logic [RANK_W-1:0]    rnk   [WAYS];
  logic [TID_BITS-1:0]  own   [WAYS];
  logic [ADDR_BITS-1:0] tg    [WAYS];
  logic                 in_use [WAYS];
  logic                 hit_c, any_inv, vic_valid, newer;
  logic [WAY_W-1:0]     hit_way, inv_way, lru_way, victim;
  logic [RANK_W-1:0]    vic_rank;

  sac_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (q_set_i),
    .rdata_o (ram_rdata)
  );

  // unpack the set row
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      {vld[w], rnk[w], own[w], tg[w]} = ram_rdata[w*EW +: EW];
      in_use[w] = (w == 0) || (32'(w) < 32'(cfg_i.ways_in_use));
    end
  end

  // hit search, first invalid way, oldest valid way
  always_comb begin
    hit_c   = 1'b0;
    any_inv = 1'b0;
    hit_way = '0;
    inv_way = '0;
    lru_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (in_use[w] && vld[w] && tg[w] == tag_q && own[w] == tid_q) begin
        hit_c   = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (in_use[w] && !vld[w]) begin
        any_inv = 1'b1;
        inv_way = WAY_W'(w);
      end
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      newer = 1'b0;
      for (int j = 0; j < WAYS; j++) begin
        if (in_use[j] && vld[j] && rnk[j] > rnk[w]) begin
          newer = 1'b1;
        end
      end
      if (in_use[w] && vld[w] && !newer) begin
        lru_way = WAY_W'(w);
      end
    end
    victim = hit_c ? hit_way : (any_inv ? inv_way : lru_way);
  end

  // touched way goes to rank 0, younger valid lines age by one (all valid lines if it was invalid)
  always_comb begin
    vic_valid = 1'b0;
    vic_rank  = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == victim) begin
        vic_valid = vld[w];
        vic_rank  = rnk[w];
      end
    end
    new_row = ram_rdata;
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == victim) begin
        new_row[w*EW +: EW] = {1'b1, {RANK_W{1'b0}}, tid_q, tag_q};
      end else if (vld[w] && (!vic_valid || rnk[w] < vic_rank)) begin
        new_row[w*EW +: EW] = {1'b1, rnk[w] + 1'b1, own[w], tg[w]};
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_CLEAR: begin
        if (clr_cnt_q == SETW'(SETS - 1)) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid_i) begin
          state_d = BK_LOOK;
        end
      end
      BK_LOOK: state_d = BK_IDLE;
      default: state_d = BK_CLEAR;
    endcase
  end

  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = set_q;
    ram_wdata  = new_row;
    q_pop_o    = 1'b0;
    clearing_o = 1'b0;
    case (state_q)
      BK_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_cnt_q;
        ram_wdata  = '0;
        clearing_o = 1'b1;
      end
      BK_IDLE: q_pop_o = q_valid_i;
      BK_LOOK: ram_we = 1'b1;
      default: clearing_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_CLEAR;
      clr_cnt_q <= '0;
      rv_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= (state_q == BK_LOOK);
      if (state_q == BK_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      set_q <= q_set_i;
      tag_q <= q_tag_i;
      tid_q <= q_tid_i;
    end
    if (state_q == BK_LOOK) begin
      hit_q <= hit_c;
    end
  end

  assign hit_o          = hit_q;
  assign result_valid_o = rv_q;

endmodule

[hw/rtl/set_assoc_lru_cache_lookup_core.sv]
// Channel  | Dir | Ports                                    | Beat taken when
// ---------+-----+------------------------------------------+-----------------------------
// access   | in  | access_address_i, thread_id_i            | start && !busy at clk_i rise
// result   | out | hit_o                                    | result_valid_o high (1 cycle)
// config   | in  | cfg_idx_i, cfg_wdata_i                   | cfg_we_i at clk_i rise
//
// The back end pops a beat in IDLE while the row RAM reads its set row; in LOOK it
// compares, picks the way, writes the row back and registers the result.
// A beat is popped only in IDLE, so the back end takes no new beat until LOOK is done.
// After reset busy stays high while the row RAM is cleared, one row a cycle. The result
// side has no backpressure. The front splits the address in a 2-stage pipeline and parks
// beats in a 2-entry queue; otherwise busy rises only when a beat waits on that full queue.
module set_assoc_lru_cache_lookup_core #(
  parameter int unsigned SETS      = 1024,
  parameter int unsigned WAYS      = 8,
  parameter int unsigned ADDR_BITS = 48,
  parameter int unsigned TID_BITS  = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [ADDR_BITS-1:0]          access_address_i,
  input  logic [TID_BITS-1:0]           thread_id_i,
  output logic                          hit_o,
  output logic                          result_valid_o,
  input  logic                          cfg_we_i,
  input  logic [sac_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sac_pkg::CFG_W-1:0]     cfg_wdata_i
);

  import sac_pkg::*;

  localparam int unsigned SETW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned QW      = SETW + ADDR_BITS + TID_BITS;
  localparam int unsigned Q_DEPTH = 2;

  cfg_t                 cfg_q;
  logic                 accept;
  logic                 front_stall, clearing;
  logic                 push, q_full, q_empty, q_pop;
  logic [SETW-1:0]      f_set, q_set;
  logic [ADDR_BITS-1:0] f_tag, q_tag;
  logic [TID_BITS-1:0]  f_tid, q_tid;

  assign busy   = clearing || front_stall;
  assign accept = start && !busy;

  // config writes; unused index is ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_offset_bits <= LINE_OFFSET_RST;
      cfg_q.set_index_bits   <= SET_INDEX_RST;
      cfg_q.ways_in_use      <= WAYS_IN_USE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LINE_OFFSET: cfg_q.line_offset_bits <= cfg_wdata_i;
        CFG_SET_INDEX:   cfg_q.set_index_bits   <= cfg_wdata_i;
        CFG_WAYS_IN_USE: cfg_q.ways_in_use      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // front: strip offset, split tag and set
  sac_front #(
    .ADDR_BITS (ADDR_BITS),
    .TID_BITS  (TID_BITS),
    .SETS      (SETS),
    .SETW      (SETW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (accept),
    .addr_i     (access_address_i),
    .tid_i      (thread_id_i),
    .stall_o    (front_stall),
    .push_o     (push),
    .full_i     (q_full),
    .set_o      (f_set),
    .tag_o      (f_tag),
    .tid_o      (f_tid)
  );

  // decoupling queue between front and back
  sac_fifo #(
    .WIDTH (QW),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({f_set, f_tag, f_tid}),
    .pop_i   (q_pop),
    .rdata_o ({q_set, q_tag, q_tid}),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back: row read-modify-write, LRU update, result
  sac_back #(
    .ADDR_BITS (ADDR_BITS),
    .TID_BITS  (TID_BITS),
    .SETS      (SETS),
    .SETW      (SETW),
    .WAYS      (WAYS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (!q_empty),
    .q_set_i        (q_set),
    .q_tag_i        (q_tag),
    .q_tid_i        (q_tid),
    .q_pop_o        (q_pop),
    .clearing_o     (clearing),
    .hit_o          (hit_o),
    .result_valid_o (result_valid_o)
  );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import sac_pkg::*;

  localparam int unsigned SETS   = 1024;
  localparam int unsigned WAYS   = 8;
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned TID_W  = 8;

  // Index 3 is not a register; writes there must leave the config alone
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // Cycles to let pass after the last result before touching config or ending
  localparam int unsigned SETTLE_CYCLES = 10;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TID_W-1:0]  tid;
  } access_t;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT signals (all inputs known from time 0)
  // ---------------------------------------------------------------------------
  logic                 clk_i            = 1'b0;
  logic                 rst_ni           = 1'b0;
  logic                 start            = 1'b0;
  logic                 busy;
  logic [ADDR_W-1:0]    access_address_i = '0;
  logic [TID_W-1:0]     thread_id_i      = '0;
  logic                 hit_o;
  logic                 result_valid_o;
  logic                 cfg_we_i         = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i        = '0;
  logic [CFG_W-1:0]     cfg_wdata_i      = '0;

  always #5 clk_i = ~clk_i;

  set_assoc_lru_cache_lookup_core #(
    .SETS      (SETS),
    .WAYS      (WAYS),
    .ADDR_BITS (ADDR_W),
    .TID_BITS  (TID_W)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .access_address_i (access_address_i),
    .thread_id_i      (thread_id_i),
    .hit_o            (hit_o),
    .result_valid_o   (result_valid_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // Shadow cache: config copy plus per-line valid/tag/owner/rank
  // ---------------------------------------------------------------------------
  int unsigned       shadow_off  = LINE_OFFSET_RST;
  int unsigned       shadow_sib  = SET_INDEX_RST;
  int unsigned       shadow_ways = WAYS_IN_USE_RST;

  bit                line_valid_q [SETS*WAYS];
  logic [63:0]       line_tag_q   [SETS*WAYS];
  logic [TID_W-1:0]  line_owner_q [SETS*WAYS];
  int unsigned       line_rank_q  [SETS*WAYS];

  access_t           pending_q[$];      // accesses waiting to be driven
  bit                hit_expected_q[$]; // predicted hit flags, oldest first

  int unsigned       sender_idle_pct = 0;
  int unsigned       mismatch_count  = 0;

  // Rank 0 is most recent. Touching a valid line of rank r ages every valid
  // line younger than r; filling an invalid way ages every valid line.
  function automatic void promote_way(int unsigned base, int unsigned w);
    int unsigned limit;
    limit = line_valid_q[base+w] ? line_rank_q[base+w] : WAYS;
    for (int unsigned i = 0; i < WAYS; i++) begin
      if (i != w && line_valid_q[base+i] && line_rank_q[base+i] < limit)
        line_rank_q[base+i]++;
    end
    line_rank_q[base+w] = 0;
  endfunction

  // Looks the access up in the shadow cache, updates it, returns the hit flag
  function automatic bit predict_hit(logic [ADDR_W-1:0] addr, logic [TID_W-1:0] tid);
    logic [63:0] line_addr;
    logic [63:0] tag;
    int unsigned set_idx;
    int unsigned base;
    int unsigned nways;
    int unsigned victim;
    int          best_rank;
    bit          have_invalid;
    line_addr = 64'(addr) >> shadow_off;
    // set index wider than the array folds back modulo SETS
    set_idx   = 32'((line_addr & ((64'd1 << shadow_sib) - 64'd1)) % SETS);
    tag       = line_addr >> shadow_sib;
    base      = set_idx * WAYS;
    nways     = shadow_ways;
    if (nways == 0) nways = 1;
    if (nways > WAYS) nways = WAYS;
    victim       = 0;
    best_rank    = -1;
    have_invalid = 1'b0;

    for (int unsigned w = 0; w < nways; w++) begin
      if (line_valid_q[base+w] && line_tag_q[base+w] == tag && line_owner_q[base+w] == tid) begin
        promote_way(base, w);
        return 1'b1;
      end
    end

    // first invalid way wins; otherwise the oldest valid way
    for (int unsigned w = 0; w < nways; w++) begin
      if (!line_valid_q[base+w]) begin
        if (!have_invalid) begin
          have_invalid = 1'b1;
          victim       = w;
        end
      end else if (!have_invalid && int'(line_rank_q[base+w]) > best_rank) begin
        best_rank = int'(line_rank_q[base+w]);
        victim    = w;
      end
    end

    promote_way(base, victim);
    line_valid_q[base+victim] = 1'b1;
    line_tag_q[base+victim]   = tag;
    line_owner_q[base+victim] = tid;
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one beat per start && !busy edge; start held while busy
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : drv
    access_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        hit_expected_q.push_back(predict_hit(access_address_i, thread_id_i));
      if (!(start && busy)) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          nxt              = pending_q.pop_front();
          start            <= 1'b1;
          access_address_i <= nxt.addr;
          thread_id_i      <= nxt.tid;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : mon
    bit exp_hit;
    if (rst_ni && result_valid_o) begin
      if (hit_expected_q.size() == 0) begin
        $error("hit: result with nothing expected, actual %0b", hit_o);
        mismatch_count++;
      end else begin
        exp_hit = hit_expected_q.pop_front();
        if (hit_o !== exp_hit) begin
          $error("hit mismatch: expected %0b, actual %0b", exp_hit, hit_o);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_access(logic [ADDR_W-1:0] addr, logic [TID_W-1:0] tid);
    access_t a;
    a.addr = addr;
    a.tid  = tid;
    pending_q.push_back(a);
  endtask

  // Wait until every access is driven and answered; sampled on the falling
  // edge so the driver's edge updates are settled.
  task automatic drain();
    while (pending_q.size() != 0 || start || hit_expected_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_LINE_OFFSET: shadow_off  = val;
      CFG_SET_INDEX:   shadow_sib  = val;
      CFG_WAYS_IN_USE: shadow_ways = val;
      default: ;
    endcase
  endtask

  // Mostly a handful of sets, a dozen tags and three threads so that sets
  // fill, hit and evict; the rest is full-range noise.
  function automatic access_t make_access();
    access_t     a;
    logic [63:0] set_sel;
    logic [63:0] tag_sel;
    logic [63:0] word;
    if ($urandom_range(0, 99) < 12) begin
      a.addr = ADDR_W'({$urandom, $urandom});
      a.tid  = TID_W'($urandom);
    end else begin
      // bit 10 of the set aliases onto the same set when the index is too wide
      set_sel = 64'($urandom_range(0, 3)) | (64'($urandom_range(0, 1)) << 10);
      set_sel = set_sel & ((64'd1 << shadow_sib) - 64'd1);
      tag_sel = 64'($urandom_range(0, 11));
      word    = (tag_sel << (shadow_off + shadow_sib)) | (set_sel << shadow_off)
              | (64'($urandom) & ((64'd1 << shadow_off) - 64'd1));
      a.addr  = ADDR_W'(word);
      a.tid   = TID_W'($urandom_range(0, 2));
    end
    return a;
  endfunction

  task automatic run_phase(logic [CFG_W-1:0] off, logic [CFG_W-1:0] sib,
                           logic [CFG_W-1:0] ways, bit poke_unused,
                           int unsigned idle_pct, int unsigned n_items);
    drain();
    write_reg(CFG_LINE_OFFSET, off);
    write_reg(CFG_SET_INDEX, sib);
    write_reg(CFG_WAYS_IN_USE, ways);
    if (poke_unused) write_reg(CFG_UNUSED_IDX, 4'hF);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sender_idle_pct = idle_pct;
    repeat (n_items) pending_q.push_back(make_access());
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int unsigned i = 0; i < SETS*WAYS; i++) begin
      line_valid_q[i] = 1'b0;
      line_tag_q[i]   = '0;
      line_owner_q[i] = '0;
      line_rank_q[i]  = 0;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset config (64 B lines, 1024 sets, 8 ways): set 0 is
    // addr = tag << 16.
    queue_access(48'h0, 8'h00);             // cold miss
    queue_access(48'h0, 8'h00);             // hit
    queue_access(48'h3F, 8'h00);            // offset bits ignored: hit
    queue_access(48'h0, 8'hFF);             // same tag, other thread: miss
    queue_access('1, 8'hFF);                // all-ones address: miss
    queue_access('1, 8'hFF);                // hit
    queue_access(48'h40, 8'hA5);            // set 1
    for (int unsigned t = 1; t <= 7; t++)   // fill set 0, last one evicts LRU
      queue_access(ADDR_W'(t) << 16, 8'h00);
    queue_access(48'h0, 8'h00);             // evicted: miss, refill
    queue_access(48'h7_0000, 8'h00);        // still resident: hit
    queue_access(48'h0, 8'hFF);
    queue_access(48'h1_0000, 8'h5A);        // tag 1 already evicted: miss
    queue_access(48'h8000_0000_0000, 8'h01);
    queue_access(48'h8000_0000_0000, 8'h01);

    // Random phases: extremes and out-of-range settings, lines kept across
    run_phase(4'd2,  4'd0,  4'd1,  1'b0, 0,  130);
    run_phase(4'd12, 4'd10, 4'd8,  1'b0, 55, 130);
    run_phase(4'd6,  4'd2,  4'd4,  1'b0, 9,  130);
    run_phase(4'd15, 4'd15, 4'd0,  1'b1, 0,  130);  // ways 0 acts as 1
    run_phase(4'd0,  4'd12, 4'd15, 1'b0, 55, 130);  // ways 15 acts as WAYS
    run_phase(4'd5,  4'd1,  4'd3,  1'b0, 9,  130);
    run_phase(4'd6,  4'd10, 4'd8,  1'b0, 0,  130);
    drain();

    if (mismatch_count == 0)
      $display("set_assoc_lru_cache_lookup_core test passed");
    else
      $display("set_assoc_lru_cache_lookup_core test failed");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (clear pass + ~900 beats)
  initial begin
    #2_000_000;
    $display("set_assoc_lru_cache_lookup_core test failed");
    $finish;
  end

endmodule
